### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### hdl/tlrg_pkg.sv
package tlrg_pkg;

    // size field width, fixed across the block and its interfaces
    localparam int SIZE_BITS = 16;

    localparam logic [2:0] STYLE_TILE    = 3'd0;
    localparam logic [2:0] STYLE_SPIRAL  = 3'd1;
    localparam logic [2:0] STYLE_DIM     = 3'd2;
    localparam logic [2:0] STYLE_COLUMNS = 3'd3;
    localparam logic [2:0] STYLE_ROWS    = 3'd4;
    localparam logic [2:0] STYLE_GRID    = 3'd5;

    localparam logic [2:0] CFG_STYLE  = 3'd0;
    localparam logic [2:0] CFG_MAIN   = 3'd1;
    localparam logic [2:0] CFG_RATIO  = 3'd2;
    localparam logic [2:0] CFG_VPAD   = 3'd3;
    localparam logic [2:0] CFG_OPAD   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] RATIO_MIN = 16'd6553;
    localparam logic [15:0] RATIO_MAX = 16'd58982;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SIZE = 6'b000010,
        ST_PREP = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_EMIT = 6'b010000,
        ST_HOLD = 6'b100000
    } t_state;

    // smallest g with g*g >= n, n up to 64
    function automatic logic [3:0] ceil_sqrt(input logic [6:0] n);
        logic [3:0] g;
        g = 4'd8;
        for (int k = 8; k >= 1; k--) begin
            if (7'(k * k) >= n || k == 8) begin
                if (k * k >= int'(n)) g = 4'(k);
            end
        end
        return g;
    endfunction

endpackage

### hdl/tlrg_dem_if.sv
interface tlrg_dem_if
    import tlrg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [7:0]           num_views;
    logic [SIZE_BITS-1:0] area_width;
    logic [SIZE_BITS-1:0] area_height;
    logic [31:0]          demand_serial;

    modport source(output valid, num_views, area_width, area_height, demand_serial,
                   input ready);
    modport sink(input valid, num_views, area_width, area_height, demand_serial,
                 output ready);
endinterface

### hdl/tlrg_rect_if.sv
interface tlrg_rect_if
    import tlrg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [4:0]           view_index;
    logic                 is_view;
    logic [SIZE_BITS:0]   pos_x;
    logic [SIZE_BITS:0]   pos_y;
    logic [SIZE_BITS-1:0] rect_width;
    logic [SIZE_BITS-1:0] rect_height;
    logic [31:0]          serial_echo;
    logic                 last_rect;

    modport source(output valid, view_index, is_view, pos_x, pos_y, rect_width,
                   rect_height, serial_echo, last_rect, input ready);
    modport sink(input valid, view_index, is_view, pos_x, pos_y, rect_width,
                 rect_height, serial_echo, last_rect, output ready);
endinterface

### hdl/tiling_layout_rect_generator.sv
// Tiling layout rectangle generator.
// i_dem carries one layout request (view count, area size, serial); o_rect
// returns one padded rectangle per view in index order, last_rect marking the
// final one. A count of zero gives a single marker with is_view low.
// Configuration (style, main count, ratio, paddings) is written on the i_cfg_*
// port; the user must write it only while no request is in progress, as the
// block does not enforce this. It takes effect on the next request.
// Sequence: a request is sized (ST_SIZE, ST_PREP), then one restoring divider
// is reused for up to two quotients, then each rectangle is built (ST_EMIT)
// and presented (ST_HOLD). i_dem.ready is high only when idle, so a new request
// is taken only after the last rectangle of the previous one is accepted.
// The divider gives one quotient bit per cycle; a single output register holds each rectangle.
// Reset (synchronous, active low) returns the sequencer to idle, drops
// o_rect.valid and loads the configuration defaults. When the receiver holds
// o_rect.ready low the current rectangle stays on the port unchanged and the
// sequencer waits.
module tiling_layout_rect_generator
    import tlrg_pkg::*;
#(
    parameter int MAX_VIEWS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlrg_dem_if.sink              i_dem,
    tlrg_rect_if.source           o_rect
);
    `include "assert_macros.svh"

    localparam int S     = SIZE_BITS;
    localparam int CNT_W = ($clog2(MAX_VIEWS + 1) > 2) ? $clog2(MAX_VIEWS + 1) : 2;
    localparam int PW    = ((S > 13) ? S : 13) + 2;
    localparam int DC_W  = $clog2(S + 1);

    // configuration
    logic [2:0]  r_style;
    logic [7:0]  r_main;
    logic [15:0] r_ratio;
    logic [11:0] r_vpad;
    logic [11:0] r_opad;

    t_state r_state, n_state;

    // request
    logic [CNT_W-1:0] r_n;
    logic [S-1:0]     r_aw, r_ah, r_w, r_h, r_msize;
    logic [31:0]      r_serial;

    // divider
    logic [S-1:0]     r_div_num, n_div_num;
    logic [CNT_W-1:0] r_div_den, n_div_den;
    logic [CNT_W-1:0] r_div_rem, n_div_rem;
    logic [DC_W-1:0]  r_div_cnt, n_div_cnt;
    logic             r_div_sel, n_div_sel;
    logic [S-1:0]     r_qa, n_qa, r_qb, n_qb;

    // walk
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_col, n_col;
    logic [S-1:0]     r_ax, n_ax, r_ay, n_ay, r_vw, n_vw, r_vh, n_vh;

    // output register
    logic             r_ovalid, n_ovalid;
    logic [4:0]       r_oidx;
    logic             r_oisv, r_olast;
    logic [S:0]       r_ox, r_oy;
    logic [S-1:0]     r_ow, r_oh;
    logic [S:0]       n_ox, n_oy;
    logic [S-1:0]     n_ow, n_oh;
    logic             n_olast;

    logic             dem_acc;
    logic [CNT_W-1:0] n_clamped;
    logic [PW-1:0]    op2, vp2, padsum;
    logic [S-1:0]     w_calc, h_calc;
    logic [S+15:0]    prod;
    logic [15:0]      ratio_sat;
    logic             is_tile, is_spiral, is_dim, is_cols, is_rows, is_grid;
    logic             need_a, need_b;
    logic [S-1:0]     a_num, b_num;
    logic [CNT_W-1:0] a_den, b_den, mc_min, g;
    logic [CNT_W:0]   rem_sh;
    logic             qbit;
    logic [S-1:0]     div_res;
    logic             last_i, in_main;
    logic [7:0]       i_ext;
    logic [S-1:0]     ex, ey, ew, eh, hw, hh;

    function automatic logic [S-1:0] sat_sub(input logic [S-1:0] a, input logic [PW-1:0] b);
        return (PW'(a) > b) ? S'(PW'(a) - b) : '0;
    endfunction

    assign dem_acc     = i_dem.valid && i_dem.ready;
    assign i_dem.ready = (r_state == ST_IDLE);

    assign n_clamped = (i_dem.num_views > 8'(MAX_VIEWS)) ? CNT_W'(MAX_VIEWS)
                                                          : CNT_W'(i_dem.num_views);

    assign op2    = PW'({r_opad, 1'b0});
    assign vp2    = PW'({r_vpad, 1'b0});
    assign padsum = PW'(r_vpad) + PW'(r_opad);
    assign w_calc = sat_sub(r_aw, op2);
    assign h_calc = sat_sub(r_ah, op2);

    assign ratio_sat = (r_ratio < RATIO_MIN) ? RATIO_MIN :
                       (r_ratio > RATIO_MAX) ? RATIO_MAX : r_ratio;
    assign prod      = (S + 16)'(r_w) * (S + 16)'(ratio_sat);

    assign is_spiral = (r_style == STYLE_SPIRAL);
    assign is_dim    = (r_style == STYLE_DIM);
    assign is_cols   = (r_style == STYLE_COLUMNS);
    assign is_rows   = (r_style == STYLE_ROWS);
    assign is_grid   = (r_style == STYLE_GRID);
    assign is_tile   = !(is_spiral || is_dim || is_cols || is_rows || is_grid);

    assign mc_min = (r_main < 8'(r_n)) ? CNT_W'(r_main) : r_n;
    assign g      = CNT_W'(ceil_sqrt(7'(r_n)));

    assign need_a = is_tile ? (r_main != 8'd0) : (is_cols || is_rows || is_grid);
    assign need_b = is_tile ? (8'(r_n) > r_main) : is_grid;
    assign a_num  = (is_cols || is_grid) ? r_w : r_h;
    assign a_den  = is_tile ? mc_min : (is_grid ? g : r_n);
    assign b_num  = r_h;
    assign b_den  = is_grid ? g : CNT_W'(8'(r_n) - r_main);

    // restoring divider step
    assign rem_sh  = {r_div_rem, r_div_num[S-1]};
    assign qbit    = (rem_sh >= {1'b0, r_div_den});
    assign div_res = {r_div_num[S-2:0], qbit};

    // rectangle build
    assign last_i  = (r_i == r_n - CNT_W'(1));
    assign i_ext   = 8'(r_i);
    assign in_main = (i_ext < r_main);
    assign hw      = r_vw >> 1;
    assign hh      = r_vh >> 1;

    always_comb begin
        n_state   = r_state;
        n_div_num = r_div_num;
        n_div_den = r_div_den;
        n_div_rem = r_div_rem;
        n_div_cnt = r_div_cnt;
        n_div_sel = r_div_sel;
        n_qa      = r_qa;
        n_qb      = r_qb;
        n_i       = r_i;
        n_col     = r_col;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_vw      = r_vw;
        n_vh      = r_vh;
        n_ovalid  = r_ovalid;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_ow      = r_ow;
        n_oh      = r_oh;
        n_olast   = r_olast;
        ex        = '0;
        ey        = '0;
        ew        = '0;
        eh        = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (dem_acc) n_state = ST_SIZE;
            end
            ST_SIZE: begin
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_i   = '0;
                n_col = '0;
                n_ax  = '0;
                n_ay  = '0;
                n_vw  = r_w;
                n_vh  = r_h;
                n_div_rem = '0;
                n_div_cnt = DC_W'(S);
                if (r_n != '0 && need_a) begin
                    n_div_num = a_num;
                    n_div_den = a_den;
                    n_div_sel = 1'b0;
                    n_state   = ST_DIV;
                end else if (r_n != '0 && need_b) begin
                    n_div_num = b_num;
                    n_div_den = b_den;
                    n_div_sel = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                n_div_num = div_res;
                n_div_rem = qbit ? CNT_W'(rem_sh - {1'b0, r_div_den}) : CNT_W'(rem_sh);
                n_div_cnt = r_div_cnt - DC_W'(1);
                if (r_div_cnt == DC_W'(1)) begin
                    if (!r_div_sel) begin
                        n_qa = div_res;
                        if (need_b) begin
                            n_div_num = b_num;
                            n_div_den = b_den;
                            n_div_rem = '0;
                            n_div_cnt = DC_W'(S);
                            n_div_sel = 1'b1;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_qb    = div_res;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (r_n == '0) begin
                    n_ox    = '0;
                    n_oy    = '0;
                    n_ow    = '0;
                    n_oh    = '0;
                    n_olast = 1'b1;
                end else begin
                    if (is_spiral || is_dim) begin
                        ex = r_ax;
                        ey = r_ay;
                        if (!last_i) begin
                            if (!r_i[0]) begin
                                n_vw = hw;
                                if (r_i[1] && !is_dim) ex = r_ax + hw;
                                else n_ax = r_ax + hw;
                            end else begin
                                n_vh = hh;
                                if (r_i[1] && !is_dim) ey = r_ay + hh;
                                else n_ay = r_ay + hh;
                            end
                        end
                        ew = sat_sub(n_vw, vp2);
                        eh = sat_sub(n_vh, vp2);
                    end else if (is_cols) begin
                        ex   = r_ax;
                        ew   = sat_sub(r_qa, vp2);
                        eh   = r_h;
                        n_ax = r_ax + r_qa;
                    end else if (is_rows) begin
                        ey   = r_ay;
                        ew   = r_w;
                        eh   = sat_sub(r_qa, vp2);
                        n_ay = r_ay + r_qa;
                    end else if (is_grid) begin
                        ex = r_ax;
                        ey = r_ay;
                        ew = sat_sub(r_qa, vp2);
                        eh = sat_sub(r_qb, vp2);
                        if (r_col + CNT_W'(1) == g) begin
                            n_col = '0;
                            n_ax  = '0;
                            n_ay  = r_ay + r_qb;
                        end else begin
                            n_col = r_col + CNT_W'(1);
                            n_ax  = r_ax + r_qa;
                        end
                    end else begin
                        ey = r_ay;
                        if (in_main) begin
                            ex = '0;
                            ew = sat_sub(r_msize, vp2);
                            eh = sat_sub(r_qa, vp2);
                            n_ay = (i_ext + 8'd1 == r_main) ? '0 : r_ay + r_qa;
                        end else begin
                            ex = r_msize;
                            ew = sat_sub(r_w - r_msize, vp2);
                            eh = sat_sub(r_qb, vp2);
                            n_ay = r_ay + r_qb;
                        end
                    end
                    n_ox = (S + 1)'(PW'(ex) + padsum);
                    n_oy = (S + 1)'(PW'(ey) + padsum);
                    n_ow = ew;
                    n_oh = eh;
                    if (is_cols) n_oy = (S + 1)'(PW'(r_opad));
                    if (is_rows) n_ox = (S + 1)'(PW'(r_opad));
                    n_olast = last_i;
                end
                n_ovalid = 1'b1;
                n_state  = ST_HOLD;
            end
            ST_HOLD: begin
                if (o_rect.ready) begin
                    n_ovalid = 1'b0;
                    n_i      = r_i + CNT_W'(1);
                    n_state  = r_olast ? ST_IDLE : ST_EMIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_style  <= STYLE_TILE;
            r_main   <= 8'd1;
            r_ratio  <= 16'd32768;
            r_vpad   <= 12'd5;
            r_opad   <= 12'd5;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STYLE: r_style <= i_cfg_data[2:0];
                    CFG_MAIN:  r_main  <= i_cfg_data[7:0];
                    CFG_RATIO: r_ratio <= i_cfg_data;
                    CFG_VPAD:  r_vpad  <= i_cfg_data[11:0];
                    CFG_OPAD:  r_opad  <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dem_acc) begin
            r_n      <= n_clamped;
            r_aw     <= i_dem.area_width;
            r_ah     <= i_dem.area_height;
            r_serial <= i_dem.demand_serial;
        end
        if (r_state == ST_SIZE) begin
            r_w <= w_calc;
            r_h <= h_calc;
        end
        if (r_state == ST_PREP) begin
            if (r_main == 8'd0)          r_msize <= '0;
            else if (8'(r_n) <= r_main)  r_msize <= r_w;
            else                         r_msize <= prod[S+15:16];
        end
        if (r_state == ST_EMIT) begin
            r_oidx <= 5'(r_i);
            r_oisv <= (r_n != '0);
        end
        r_div_num <= n_div_num;
        r_div_den <= n_div_den;
        r_div_rem <= n_div_rem;
        r_div_cnt <= n_div_cnt;
        r_div_sel <= n_div_sel;
        r_qa      <= n_qa;
        r_qb      <= n_qb;
        r_i       <= n_i;
        r_col     <= n_col;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_vw      <= n_vw;
        r_vh      <= n_vh;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_ow      <= n_ow;
        r_oh      <= n_oh;
        r_olast   <= n_olast;
    end

    assign o_rect.valid       = r_ovalid;
    assign o_rect.view_index  = r_oidx;
    assign o_rect.is_view     = r_oisv;
    assign o_rect.pos_x       = r_ox;
    assign o_rect.pos_y       = r_oy;
    assign o_rect.rect_width  = r_ow;
    assign o_rect.rect_height = r_oh;
    assign o_rect.serial_echo = r_serial;
    assign o_rect.last_rect   = r_olast;

    `ASSERT_NEVER(a_no_zero_div, i_clk, i_rst_n, r_state == ST_DIV && r_div_den == '0)
    `ASSERT_NEVER(a_busy_or_ready, i_clk, i_rst_n, i_dem.ready && o_rect.valid)
    `ASSERT_IMPL(a_last_index, i_clk, i_rst_n, o_rect.valid && o_rect.last_rect && o_rect.is_view, o_rect.view_index == 5'(r_n - CNT_W'(1)))

endmodule

### tb/testbench.sv
module testbench;
    import tlrg_pkg::*;

    localparam int MAX_VIEWS = 32;
    localparam int LIMIT     = 3000000;
    // register index that the block does not decode
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam logic [2:0] STYLE_ALIAS = 3'd6;
    localparam logic [2:0] STYLE_ALIAS_HI = 3'd7;

    typedef struct packed {
        logic [4:0]  view_index;
        logic        is_view;
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [31:0] serial_echo;
        logic        last_rect;
    } t_rect;

    typedef struct {
        logic [2:0]  style;
        logic [7:0]  num_views;
        logic [15:0] area_width;
        logic [15:0] area_height;
        logic [31:0] serial;
        bit          typed;
        t_rect       rect;
    } t_row;

    logic i_clk, i_rst_n, i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tlrg_dem_if  dem();
    tlrg_rect_if rect();

    tiling_layout_rect_generator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_dem(dem), .o_rect(rect)
    );

    // register shadow
    logic [2:0]  sh_style;
    logic [7:0]  sh_main;
    logic [15:0] sh_ratio;
    logic [11:0] sh_vpad, sh_opad;

    t_rect pending_rects[$];
    int    errors;
    int    cycles;
    bit    no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic int unsigned sat(int unsigned a, int unsigned b);
        return a > b ? a - b : 0;
    endfunction

    function automatic void push_rect(int unsigned idx, int unsigned x, int unsigned y,
                                      int unsigned w, int unsigned h,
                                      logic [31:0] serial, bit last);
        t_rect r;
        r.view_index  = idx[4:0];
        r.is_view     = 1'b1;
        r.pos_x       = x[16:0];
        r.pos_y       = y[16:0];
        r.rect_width  = w[15:0];
        r.rect_height = h[15:0];
        r.serial_echo = serial;
        r.last_rect   = last;
        pending_rects.push_back(r);
    endfunction

    // lays out one accepted request and queues its rectangles
    function automatic void layout_request(logic [7:0] count, logic [15:0] aw,
                                           logic [15:0] ah, logic [31:0] serial);
        int unsigned n, w, h, vp, op, vp2, lst, slot, g, cw, ch;
        int unsigned vx, vy, vw, vh, x, y, mc, ratio, msize, ssize;
        bit dim;
        t_rect r;
        n = count;
        if (n > MAX_VIEWS) n = MAX_VIEWS;
        if (n == 0) begin
            r = '0;
            r.serial_echo = serial;
            r.last_rect   = 1'b1;
            pending_rects.push_back(r);
            return;
        end
        vp = sh_vpad; op = sh_opad; vp2 = 2 * vp;
        w = sat(aw, 2 * op);
        h = sat(ah, 2 * op);
        lst = n - 1;
        case (sh_style)
            STYLE_SPIRAL, STYLE_DIM: begin
                dim = (sh_style == STYLE_DIM);
                vx = 0; vy = 0; vw = w; vh = h;
                for (int unsigned i = 0; i < n; i++) begin
                    x = vx; y = vy;
                    if (i != lst) begin
                        if (i[0] == 1'b0) begin
                            vw = vw / 2;
                            if (i[1:0] == 2'd2 && !dim) x = vx + vw;
                            else vx += vw;
                        end else begin
                            vh = vh / 2;
                            if (i[1:0] == 2'd3 && !dim) y = vy + vh;
                            else vy += vh;
                        end
                    end
                    push_rect(i, x + vp + op, y + vp + op, sat(vw, vp2), sat(vh, vp2),
                              serial, i == lst);
                end
            end
            STYLE_COLUMNS: begin
                slot = w / n;
                for (int unsigned i = 0; i < n; i++)
                    push_rect(i, i * slot + vp + op, op, sat(slot, vp2), h, serial, i == lst);
            end
            STYLE_ROWS: begin
                slot = h / n;
                for (int unsigned i = 0; i < n; i++)
                    push_rect(i, op, i * slot + vp + op, w, sat(slot, vp2), serial, i == lst);
            end
            STYLE_GRID: begin
                g = 1;
                while (g * g < n) g++;
                cw = w / g;
                ch = h / g;
                for (int unsigned i = 0; i < n; i++)
                    push_rect(i, (i % g) * cw + vp + op, (i / g) * ch + vp + op,
                              sat(cw, vp2), sat(ch, vp2), serial, i == lst);
            end
            default: begin
                // tile, also for the undecoded style codes
                mc = sh_main;
                ratio = sh_ratio;
                if (ratio < RATIO_MIN) ratio = RATIO_MIN;
                if (ratio > RATIO_MAX) ratio = RATIO_MAX;
                if (mc == 0) begin
                    msize = 0; ssize = w;
                end else if (n <= mc) begin
                    msize = w; ssize = 0;
                end else begin
                    msize = (longint'(w) * ratio) >> 16;
                    ssize = w - msize;
                end
                for (int unsigned i = 0; i < n; i++) begin
                    if (i < mc) begin
                        vh = h / (mc < n ? mc : n);
                        vx = 0; vw = msize; vy = i * vh;
                    end else begin
                        vh = h / (n - mc);
                        vx = msize; vw = ssize; vy = (i - mc) * vh;
                    end
                    push_rect(i, vx + vp + op, vy + vp + op, sat(vw, vp2), sat(vh, vp2),
                              serial, i == lst);
                end
            end
        endcase
    endfunction

    // result side: random stalls, compare against oldest pending rectangle
    initial begin
        int stall;
        rect.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                rect.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rect.ready <= 1'b1;
            do @(posedge i_clk); while (!(rect.valid && rect.ready));
        end
    end

    always @(posedge i_clk) begin
        t_rect e;
        if (i_rst_n && rect.valid && rect.ready) begin
            if (pending_rects.size() == 0) begin
                $error("unexpected rectangle, serial %0h", rect.serial_echo);
                errors++;
            end else begin
                e = pending_rects.pop_front();
                if (rect.view_index !== e.view_index) begin
                    $error("view_index exp %0d got %0d", e.view_index, rect.view_index);
                    errors++;
                end
                if (rect.is_view !== e.is_view) begin
                    $error("is_view exp %0d got %0d", e.is_view, rect.is_view);
                    errors++;
                end
                if (rect.pos_x !== e.pos_x) begin
                    $error("pos_x exp %0d got %0d", e.pos_x, rect.pos_x);
                    errors++;
                end
                if (rect.pos_y !== e.pos_y) begin
                    $error("pos_y exp %0d got %0d", e.pos_y, rect.pos_y);
                    errors++;
                end
                if (rect.rect_width !== e.rect_width) begin
                    $error("rect_width exp %0d got %0d", e.rect_width, rect.rect_width);
                    errors++;
                end
                if (rect.rect_height !== e.rect_height) begin
                    $error("rect_height exp %0d got %0d", e.rect_height, rect.rect_height);
                    errors++;
                end
                if (rect.serial_echo !== e.serial_echo) begin
                    $error("serial_echo exp %0h got %0h", e.serial_echo, rect.serial_echo);
                    errors++;
                end
                if (rect.last_rect !== e.last_rect) begin
                    $error("last_rect exp %0d got %0d", e.last_rect, rect.last_rect);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        dem.valid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // leaves i_cfg_we high; cfg_release drops it
    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_STYLE: sh_style = data[2:0];
            CFG_MAIN:  sh_main  = data[7:0];
            CFG_RATIO: sh_ratio = data;
            CFG_VPAD:  sh_vpad  = data[11:0];
            CFG_OPAD:  sh_opad  = data[11:0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send(logic [7:0] n, logic [15:0] aw, logic [15:0] ah,
                        logic [31:0] serial);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            dem.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        dem.valid         <= 1'b1;
        dem.num_views     <= n;
        dem.area_width    <= aw;
        dem.area_height   <= ah;
        dem.demand_serial <= serial;
        do @(posedge i_clk); while (!(dem.valid && dem.ready));
    endtask

    function automatic logic [15:0] rand_size();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 200));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_count();
        case ($urandom_range(0, 9))
            0: return 8'($urandom);
            1: return 8'd0;
            2: return 8'($urandom_range(28, 40));
            default: return 8'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [11:0] rand_pad();
        case ($urandom_range(0, 7))
            0: return 12'hFFF;
            1: return 12'($urandom);
            2: return 12'd0;
            default: return 12'($urandom_range(0, 20));
        endcase
    endfunction

    t_row rows[$];

    function automatic t_row mk(logic [2:0] s, logic [7:0] n, logic [15:0] aw,
                                logic [15:0] ah, logic [31:0] serial);
        t_row r;
        r.style = s; r.num_views = n; r.area_width = aw; r.area_height = ah;
        r.serial = serial; r.typed = 1'b0; r.rect = '0;
        return r;
    endfunction

    initial begin
        t_row r;
        errors  = 0;
        cycles  = 0;
        no_idle = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_STYLE;
        i_cfg_data <= '0;
        dem.valid         <= 1'b0;
        dem.num_views     <= '0;
        dem.area_width    <= '0;
        dem.area_height   <= '0;
        dem.demand_serial <= '0;
        sh_style = STYLE_TILE; sh_main = 8'd1; sh_ratio = 16'd32768;
        sh_vpad = 12'd5; sh_opad = 12'd5;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults first, the first two results typed in, the rest from layout_request
        r = mk(STYLE_TILE, 8'd1, 16'd100, 16'd100, 32'h0000_0001);
        r.typed = 1'b1;
        r.rect = '{5'd0, 1'b1, 17'd10, 17'd10, 16'd80, 16'd80, 32'h0000_0001, 1'b1};
        rows.push_back(r);
        r = mk(STYLE_TILE, 8'd0, 16'd640, 16'd480, 32'hFFFF_FFFF);
        r.typed = 1'b1;
        r.rect = '{5'd0, 1'b0, 17'd0, 17'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b1};
        rows.push_back(r);
        rows.push_back(mk(STYLE_TILE, 8'd3, 16'd1920, 16'd1080, 32'hA5A5_0002));
        rows.push_back(mk(STYLE_TILE, 8'd255, 16'hFFFF, 16'hFFFF, 32'h5A5A_0003));
        rows.push_back(mk(STYLE_TILE, 8'd33, 16'd0, 16'd0, 32'h0000_0004));
        rows.push_back(mk(STYLE_SPIRAL, 8'd7, 16'd1920, 16'd1080, 32'h0000_0005));
        rows.push_back(mk(STYLE_SPIRAL, 8'd32, 16'hFFFF, 16'hFFFF, 32'h0000_0006));
        rows.push_back(mk(STYLE_DIM, 8'd6, 16'd1280, 16'd720, 32'h0000_0007));
        rows.push_back(mk(STYLE_DIM, 8'd1, 16'd8, 16'd8, 32'h0000_0008));
        rows.push_back(mk(STYLE_COLUMNS, 8'd5, 16'd1000, 16'd500, 32'h0000_0009));
        rows.push_back(mk(STYLE_COLUMNS, 8'd200, 16'hFFFF, 16'd0, 32'h0000_000A));
        rows.push_back(mk(STYLE_ROWS, 8'd4, 16'd800, 16'd600, 32'h0000_000B));
        rows.push_back(mk(STYLE_ROWS, 8'd32, 16'd3, 16'hFFFF, 32'h0000_000C));
        rows.push_back(mk(STYLE_GRID, 8'd5, 16'd900, 16'd900, 32'h0000_000D));
        rows.push_back(mk(STYLE_GRID, 8'd32, 16'hFFFF, 16'hFFFF, 32'h0000_000E));
        rows.push_back(mk(STYLE_GRID, 8'd10, 16'd100, 16'd60, 32'h0000_000F));
        rows.push_back(mk(STYLE_ALIAS, 8'd4, 16'd1920, 16'd1080, 32'h0000_0010));
        rows.push_back(mk(STYLE_ALIAS_HI, 8'd4, 16'd1920, 16'd1080, 32'h0000_0011));

        foreach (rows[k]) begin
            if (rows[k].style != sh_style) begin
                drain();
                cfg_write(CFG_STYLE, 16'(rows[k].style));
                cfg_release();
            end
            send(rows[k].num_views, rows[k].area_width, rows[k].area_height, rows[k].serial);
            if (rows[k].typed)
                pending_rects.push_back(rows[k].rect);
            else
                layout_request(rows[k].num_views, rows[k].area_width,
                               rows[k].area_height, rows[k].serial);
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            no_idle = (ph % 4 == 3);
            cfg_write(CFG_STYLE, 16'($urandom_range(0, 7)));
            case (ph)
                0: cfg_write(CFG_MAIN, 16'd0);
                1: cfg_write(CFG_MAIN, 16'd255);
                default: cfg_write(CFG_MAIN, 16'($urandom_range(0, 6)));
            endcase
            case (ph)
                0: cfg_write(CFG_RATIO, 16'd0);
                1: cfg_write(CFG_RATIO, 16'hFFFF);
                2: cfg_write(CFG_RATIO, RATIO_MIN);
                3: cfg_write(CFG_RATIO, RATIO_MAX);
                default: cfg_write(CFG_RATIO, 16'($urandom));
            endcase
            case (ph)
                0: begin
                    cfg_write(CFG_VPAD, 16'd0);
                    cfg_write(CFG_OPAD, 16'd0);
                end
                1: begin
                    cfg_write(CFG_VPAD, 16'hFFF);
                    cfg_write(CFG_OPAD, 16'hFFF);
                end
                default: begin
                    cfg_write(CFG_VPAD, 16'(rand_pad()));
                    cfg_write(CFG_OPAD, 16'(rand_pad()));
                end
            endcase
            if (ph == 2) cfg_write(CFG_UNUSED, 16'($urandom));
            cfg_release();
            for (int k = 0; k < 26; k++) begin
                logic [7:0]  n;
                logic [15:0] aw, ah;
                logic [31:0] serial;
                n = rand_count();
                aw = rand_size();
                ah = rand_size();
                serial = $urandom;
                send(n, aw, ah, serial);
                layout_request(n, aw, ah, serial);
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_rects.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pending_rects.size() != 0)
                $error("%0d rectangles never arrived", pending_rects.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
